// ===== rtl/sde_pkg.sv =====
// ----------------------------------------------------------------------------
// sde_pkg
// Shared sizes and constants of the state delta encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sde_pkg;

  // Snapshot geometry
  localparam int unsigned BLOCK_WORDS = 16384;
  localparam int unsigned POS_W       = $clog2(BLOCK_WORDS);
  localparam int unsigned LEN_W       = 15;

  // Run buffer geometry
  localparam int unsigned MAX_RUN     = 56;
  localparam int unsigned RUN_W       = 6;
  localparam int unsigned RUN_AW      = $clog2(MAX_RUN);

  // Data widths
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned SKIP_W      = 32;
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned APB_AW      = 2;

  // Register map
  localparam logic [APB_AW-1:0] REG_BLOCK_WORDS = '0;

  // Register reset and special values
  localparam logic [LEN_W-1:0]  BW_RESET  = LEN_W'(16384);
  localparam logic [SKIP_W-1:0] SKIP_ESC  = 32'h0000_ffff;
  localparam logic [SKIP_W-1:0] SKIP_SAT  = 32'hffff_ffff;

endpackage : sde_pkg

`default_nettype wire

// ===== rtl/state_delta_encoder.sv =====
// ----------------------------------------------------------------------------
// state_delta_encoder
// Backward delta encoder: compares each snapshot word with the stored
// reference and emits count/skip/old-word runs of the patch.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o/new_word_i) takes one snapshot word
//    per item; output channel (out_valid_o/out_ready_i) gives patch words with
//    last_of_item_o on the final word of an item and frame_end_o on the last
//    terminator word of a frame.
//  - An item is accepted, then compared against the registered reference RAM
//    word; patch words follow at one per cycle while the receiver is ready.
//    A run flush streams the run buffer RAM at that rate after a count and a
//    skip word; an item causes at most 61 words.
//  - The first patch word is registered in the state after the compare state.
//  - The next item is taken once the previous one has handed its last word to
//    the output register, even while that word still waits to be taken.
//  - A stalled receiver holds the output register and the sequencer.
//  - Reset clears the position, skip and run state and the reference flag;
//    the first frame after reset or a block_words write only loads the
//    reference RAM. No clearing pass is needed.
//  - block_words is at APB address 0; write it only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module state_delta_encoder
  import sde_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Snapshot words in
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [WORD_W-1:0]   new_word_i,
  // Patch words out
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [WORD_W-1:0]   patch_word_o,
  output logic                     last_of_item_o,
  output logic                     frame_end_o,
  // Configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [APB_DW-1:0]   pwdata,
  output logic      [APB_DW-1:0]   prdata,
  output logic                     pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_ESC,
    S_FLUSH,
    S_TERM
  } state_e;

  // Control registers
  state_e              state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                have_ref_q, have_ref_d;
  logic [POS_W-1:0]    word_pos_q, word_pos_d;
  logic [SKIP_W-1:0]   pending_q, pending_d;
  logic [RUN_W-1:0]    run_len_q, run_len_d;
  logic [WORD_W-1:0]   run_skip_q, run_skip_d;
  logic [LEN_W-1:0]    block_words_q, block_words_d;
  logic                fl_pend_q, fl_pend_d;
  logic                term_pend_q, term_pend_d;
  logic [1:0]          sub_q, sub_d;
  logic [RUN_AW-1:0]   flush_idx_q, flush_idx_d;

  // Payload registers
  logic [WORD_W-1:0]   word_q, word_d;
  logic [POS_W-1:0]    item_pos_q, item_pos_d;
  logic                item_end_q, item_end_d;
  logic [SKIP_W-1:0]   esc_val_q, esc_val_d;
  logic [RUN_W-1:0]    fl_len_q, fl_len_d;
  logic [WORD_W-1:0]   fl_skip_q, fl_skip_d;
  logic [WORD_W-1:0]   patch_q, patch_d;
  logic                last_q, last_d;
  logic                fe_q, fe_d;

  // Memory ports
  logic [WORD_W-1:0]   ref_rdata;
  logic                ref_we;
  logic [WORD_W-1:0]   run_rdata;
  logic                run_we;

  logic                accept;
  logic                cfg_write;
  logic                out_free;
  logic [LEN_W-1:0]    frame_len;
  logic [LEN_W-1:0]    pos_ext;
  logic [POS_W-1:0]    pos_eff;

  assign pready    = 1'b1;
  assign prdata    = {{(APB_DW-LEN_W){1'b0}}, block_words_q};
  assign cfg_write = psel && penable && pwrite && pready && (paddr == REG_BLOCK_WORDS);

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Clamp block size and current position
  always_comb begin
    if (block_words_q == '0) begin
      frame_len = LEN_W'(1);
    end else if (block_words_q > LEN_W'(BLOCK_WORDS)) begin
      frame_len = LEN_W'(BLOCK_WORDS);
    end else begin
      frame_len = block_words_q;
    end
    pos_ext = {1'b0, word_pos_q};
    if (pos_ext >= frame_len) begin
      pos_ext = frame_len - LEN_W'(1);
    end
    pos_eff = pos_ext[POS_W-1:0];
  end

  // Reference snapshot store
  sde_ram #(
    .DEPTH (BLOCK_WORDS),
    .WIDTH (WORD_W)
  ) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (ref_we),
    .waddr_i (item_pos_q),
    .wdata_i (word_q),
    .re_i    (accept),
    .raddr_i (pos_eff),
    .rdata_o (ref_rdata)
  );

  // Old words of the open run
  sde_ram #(
    .DEPTH (MAX_RUN),
    .WIDTH (WORD_W)
  ) u_run_ram (
    .clk_i   (clk_i),
    .we_i    (run_we),
    .waddr_i (run_len_q[RUN_AW-1:0]),
    .wdata_i (ref_rdata),
    .re_i    (1'b1),
    .raddr_i (flush_idx_d),
    .rdata_o (run_rdata)
  );

  assign ref_we = (state_q == S_CMP);
  assign run_we = (state_q == S_CMP) && have_ref_q && (ref_rdata != word_q);

  // Compare, update run state and sequence patch words
  always_comb begin
    logic [RUN_W-1:0]  new_len;
    logic [WORD_W-1:0] new_skip;
    logic              esc_now;
    logic              fl_now;
    logic              last_sub;
    logic              is_last;
    state_e            after;

    state_d       = state_q;
    out_valid_d   = out_valid_q;
    have_ref_d    = have_ref_q;
    word_pos_d    = word_pos_q;
    pending_d     = pending_q;
    run_len_d     = run_len_q;
    run_skip_d    = run_skip_q;
    block_words_d = block_words_q;
    fl_pend_d     = fl_pend_q;
    term_pend_d   = term_pend_q;
    sub_d         = sub_q;
    flush_idx_d   = flush_idx_q;
    word_d        = word_q;
    item_pos_d    = item_pos_q;
    item_end_d    = item_end_q;
    esc_val_d     = esc_val_q;
    fl_len_d      = fl_len_q;
    fl_skip_d     = fl_skip_q;
    patch_d       = patch_q;
    last_d        = last_q;
    fe_d          = fe_q;
    new_len       = run_len_q;
    new_skip      = run_skip_q;
    esc_now       = 1'b0;
    fl_now        = 1'b0;
    last_sub      = 1'b0;
    is_last       = 1'b0;
    after         = S_IDLE;

    // Drop the output item once taken
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          word_d     = new_word_i;
          item_pos_d = pos_eff;
          item_end_d = (pos_ext == frame_len - LEN_W'(1));
          state_d    = S_CMP;
        end
      end

      S_CMP: begin
        if (have_ref_q) begin
          if (ref_rdata == word_q) begin
            // Unchanged word closes the open run
            if (run_len_q != '0) begin
              fl_now    = 1'b1;
              fl_len_d  = run_len_q;
              fl_skip_d = run_skip_q;
            end
            new_len  = '0;
            new_skip = '0;
            if (pending_q != SKIP_SAT) begin
              pending_d = pending_q + SKIP_W'(1);
            end
          end else begin
            // Changed word opens or extends a run
            if (run_len_q == '0) begin
              if (pending_q > SKIP_ESC) begin
                esc_now   = 1'b1;
                esc_val_d = pending_q;
                new_skip  = '0;
              end else begin
                new_skip  = pending_q[WORD_W-1:0];
              end
              pending_d = '0;
            end
            new_len = run_len_q + RUN_W'(1);
            if (new_len >= RUN_W'(MAX_RUN)) begin
              fl_now    = 1'b1;
              fl_len_d  = new_len;
              fl_skip_d = new_skip;
              new_len   = '0;
              new_skip  = '0;
            end
          end
        end
        run_len_d   = new_len;
        run_skip_d  = new_skip;
        term_pend_d = 1'b0;
        if (item_end_q) begin
          if (have_ref_q) begin
            if (new_len != '0) begin
              fl_now    = 1'b1;
              fl_len_d  = new_len;
              fl_skip_d = new_skip;
            end
            term_pend_d = 1'b1;
          end
          have_ref_d = 1'b1;
          word_pos_d = '0;
          pending_d  = '0;
          run_len_d  = '0;
          run_skip_d = '0;
        end else begin
          word_pos_d = item_pos_q + POS_W'(1);
        end
        fl_pend_d   = fl_now;
        sub_d       = '0;
        flush_idx_d = '0;
        if (esc_now) begin
          state_d = S_ESC;
        end else if (fl_now) begin
          state_d = S_FLUSH;
        end else if (term_pend_d) begin
          state_d = S_TERM;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_ESC: begin
        case (sub_q)
          2'd0:    patch_d = '0;
          2'd1:    patch_d = esc_val_q[WORD_W-1:0];
          default: patch_d = esc_val_q[SKIP_W-1:WORD_W];
        endcase
        if (!out_free) begin
          patch_d = patch_q;
        end
        last_sub = (sub_q == 2'd2);
        after    = fl_pend_q ? S_FLUSH : (term_pend_q ? S_TERM : S_IDLE);
        is_last  = last_sub && (after == S_IDLE);
        if (out_free) begin
          out_valid_d = 1'b1;
          last_d      = is_last;
          fe_d        = 1'b0;
          if (last_sub) begin
            sub_d   = '0;
            state_d = after;
          end else begin
            sub_d = sub_q + 2'd1;
          end
        end
      end

      S_FLUSH: begin
        case (sub_q)
          2'd0:    patch_d = {{(WORD_W-RUN_W){1'b0}}, fl_len_q};
          2'd1:    patch_d = fl_skip_q;
          default: patch_d = run_rdata;
        endcase
        if (!out_free) begin
          patch_d = patch_q;
        end
        last_sub = (sub_q == 2'd2) &&
                   (RUN_W'(flush_idx_q) == fl_len_q - RUN_W'(1));
        after    = term_pend_q ? S_TERM : S_IDLE;
        is_last  = last_sub && (after == S_IDLE);
        if (out_free) begin
          out_valid_d = 1'b1;
          last_d      = is_last;
          fe_d        = 1'b0;
          if (last_sub) begin
            sub_d       = '0;
            flush_idx_d = '0;
            state_d     = after;
          end else if (sub_q == 2'd2) begin
            flush_idx_d = flush_idx_q + RUN_AW'(1);
          end else begin
            sub_d = sub_q + 2'd1;
          end
        end
      end

      S_TERM: begin
        last_sub = (sub_q == 2'd2);
        if (out_free) begin
          out_valid_d = 1'b1;
          patch_d     = '0;
          last_d      = last_sub;
          fe_d        = last_sub;
          if (last_sub) begin
            sub_d   = '0;
            state_d = S_IDLE;
          end else begin
            sub_d = sub_q + 2'd1;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Register write aborts the frame
    if (cfg_write) begin
      block_words_d = pwdata[LEN_W-1:0];
      have_ref_d    = 1'b0;
      word_pos_d    = '0;
      pending_d     = '0;
      run_len_d     = '0;
      run_skip_d    = '0;
    end
  end

  // Hold state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      have_ref_q    <= 1'b0;
      word_pos_q    <= '0;
      pending_q     <= '0;
      run_len_q     <= '0;
      run_skip_q    <= '0;
      block_words_q <= BW_RESET;
      fl_pend_q     <= 1'b0;
      term_pend_q   <= 1'b0;
      sub_q         <= '0;
      flush_idx_q   <= '0;
    end else begin
      state_q       <= state_d;
      out_valid_q   <= out_valid_d;
      have_ref_q    <= have_ref_d;
      word_pos_q    <= word_pos_d;
      pending_q     <= pending_d;
      run_len_q     <= run_len_d;
      run_skip_q    <= run_skip_d;
      block_words_q <= block_words_d;
      fl_pend_q     <= fl_pend_d;
      term_pend_q   <= term_pend_d;
      sub_q         <= sub_d;
      flush_idx_q   <= flush_idx_d;
    end
  end

  // Hold item payload and output word
  always_ff @(posedge clk_i) begin
    word_q     <= word_d;
    item_pos_q <= item_pos_d;
    item_end_q <= item_end_d;
    esc_val_q  <= esc_val_d;
    fl_len_q   <= fl_len_d;
    fl_skip_q  <= fl_skip_d;
    patch_q    <= patch_d;
    last_q     <= last_d;
    fe_q       <= fe_d;
  end

  assign out_valid_o    = out_valid_q;
  assign patch_word_o   = patch_q;
  assign last_of_item_o = last_q;
  assign frame_end_o    = fe_q;

`ifndef ASSERT_OFF
  // A frame terminator always closes its item
  a_fe_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> last_of_item_o)
    else $error("frame_end without last_of_item");

  // The open run never reaches the buffer depth
  a_run_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_len_q < RUN_W'(MAX_RUN))
    else $error("open run exceeds run buffer");

  // Flush data index stays inside the flushed run
  a_flush_idx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH) |-> (RUN_W'(flush_idx_q) < fl_len_q))
    else $error("flush index beyond run length");

  // An accepted item is compared in the next cycle
  a_accept_cmp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> (state_q == S_CMP))
    else $error("accepted item not compared");
`endif

endmodule : state_delta_encoder

`default_nettype wire

// ===== rtl/sde_ram.sv =====
// ----------------------------------------------------------------------------
// sde_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sde_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : sde_ram

`default_nettype wire

// ===== tb/tb_state_delta_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_state_delta_encoder
// Self-checking bench for the state delta encoder. A clocked driver feeds
// snapshot words from a queue, a clocked monitor predicts the backward patch
// of every accepted item and checks each patch word field by field. Frame
// sizes are set over the register port between phases, with random idling
// on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_state_delta_encoder;
  import sde_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 270;
  localparam int unsigned QUIET_CYCLES = 16;
  localparam int unsigned DRAIN_LIMIT  = 200000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned RUN_LIMIT_NS = 20_000_000;

  typedef enum int unsigned {
    FRM_KEEP, FRM_FLIP, FRM_SPARSE, FRM_BURST, FRM_NOISE
  } frame_mode_e;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              item_end;
    logic              frame_end;
  } patch_word_t;

  // Clock, reset and block ports
  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [WORD_W-1:0] new_word_i     = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [WORD_W-1:0] patch_word_o;
  logic              last_of_item_o;
  logic              frame_end_o;
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [APB_AW-1:0] paddr          = '0;
  logic [APB_DW-1:0] pwdata         = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Stimulus and checking state
  logic [WORD_W-1:0] snapshot_words [$];
  patch_word_t       expected_patch [$];
  patch_word_t       step_words [$];
  bit   [WORD_W-1:0] last_sent [BLOCK_WORDS];
  logic              in_took        = 1'b0;
  int unsigned       send_gap       = 0;
  int unsigned       hold_left      = 0;
  int unsigned       long_hold_ask  = 0;
  int unsigned       long_hold_seen = 0;
  int unsigned       fault_cnt      = 0;
  int unsigned       patch_index    = 0;
  bit                calm           = 1'b0;

  // Predictor state: reference snapshot, open run and frame position
  logic [WORD_W-1:0] ref_snap [BLOCK_WORDS];
  logic [WORD_W-1:0] run_old [MAX_RUN];
  logic [LEN_W-1:0]  cfg_words      = BW_RESET;
  int unsigned       at_pos         = 0;
  logic [SKIP_W-1:0] gap_count      = '0;
  int unsigned       run_cnt        = 0;
  logic [WORD_W-1:0] run_gap        = '0;
  bit                primed         = 1'b0;

  state_delta_encoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .new_word_i     (new_word_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .patch_word_o   (patch_word_o),
    .last_of_item_o (last_of_item_o),
    .frame_end_o    (frame_end_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void log_fault(string msg);
    fault_cnt++;
    if (fault_cnt <= 10) begin
      $display("%s", msg);
    end
  endfunction

  // Mostly short gaps, now and then a long one; none in calm phases
  function automatic int unsigned pick_idle();
    int unsigned roll;
    if (calm) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      return 0;
    end else if (roll < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_word(logic [WORD_W-1:0] w, logic fe);
    step_words.push_back('{word: w, item_end: 1'b0, frame_end: fe});
  endfunction

  // Emit the open run: count, skip, then the old words
  function automatic void emit_run();
    if (run_cnt == 0) begin
      return;
    end
    add_word(WORD_W'(run_cnt), 1'b0);
    add_word(run_gap, 1'b0);
    for (int unsigned i = 0; i < run_cnt && i < MAX_RUN; i++) begin
      add_word(run_old[i], 1'b0);
    end
    run_cnt = 0;
    run_gap = '0;
  endfunction

  function automatic void load_block_words(logic [LEN_W-1:0] value);
    cfg_words = value;
    at_pos    = 0;
    gap_count = '0;
    run_cnt   = 0;
    run_gap   = '0;
    primed    = 1'b0;
  endfunction

  // Predict the patch words caused by one snapshot word
  function automatic void encode_word(logic [WORD_W-1:0] w);
    int unsigned len;
    int unsigned pos;
    logic [WORD_W-1:0] old;
    patch_word_t pw;
    len = (cfg_words == 0) ? 1 : ((cfg_words > BLOCK_WORDS) ? BLOCK_WORDS : cfg_words);
    pos = (at_pos >= len) ? len - 1 : at_pos;
    step_words.delete();
    if (primed) begin
      old = ref_snap[pos];
      if (old == w) begin
        emit_run();
        if (gap_count != SKIP_SAT) begin
          gap_count++;
        end
      end else begin
        if (run_cnt == 0) begin
          if (gap_count > SKIP_ESC) begin
            add_word('0, 1'b0);
            add_word(gap_count[15:0], 1'b0);
            add_word(gap_count[31:16], 1'b0);
            run_gap = '0;
          end else begin
            run_gap = gap_count[15:0];
          end
          gap_count = '0;
        end
        if (run_cnt < MAX_RUN) begin
          run_old[run_cnt] = old;
        end
        run_cnt++;
        if (run_cnt >= MAX_RUN) begin
          emit_run();
        end
      end
    end
    ref_snap[pos] = w;
    if (pos + 1 >= len) begin
      if (primed) begin
        emit_run();
        add_word('0, 1'b0);
        add_word('0, 1'b0);
        add_word('0, 1'b1);
      end
      primed    = 1'b1;
      at_pos    = 0;
      gap_count = '0;
      run_cnt   = 0;
      run_gap   = '0;
    end else begin
      at_pos = pos + 1;
    end
    // Mark the final word of the item
    for (int i = 0; i < step_words.size(); i++) begin
      pw = step_words[i];
      if (i == step_words.size() - 1) begin
        pw.item_end = 1'b1;
      end
      expected_patch.push_back(pw);
    end
  endfunction

  // Driver: offer the next item once the previous one is taken
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_took)) begin
      if (send_gap > 0) begin
        send_gap   <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (snapshot_words.size() != 0) begin
        in_valid_i <= 1'b1;
        new_word_i <= snapshot_words.pop_front();
        send_gap   <= pick_idle();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    int unsigned pause;
    if (rst_ni) begin
      if (long_hold_ask != long_hold_seen) begin
        long_hold_seen <= long_hold_ask;
        hold_left      <= LONG_HOLD;
        out_ready_i    <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        pause = pick_idle();
        if (pause > 0) begin
          hold_left   <= pause - 1;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  // Monitor: predict on accepted items, check accepted patch words
  always @(posedge clk_i) begin
    patch_word_t exp;
    if (!rst_ni) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        encode_word(new_word_i);
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_patch.size() == 0) begin
          log_fault($sformatf("patch word %0d: unexpected %h/%b/%b", patch_index,
                              patch_word_o, last_of_item_o, frame_end_o));
        end else begin
          exp = expected_patch.pop_front();
          if (exp.word !== patch_word_o || exp.item_end !== last_of_item_o ||
              exp.frame_end !== frame_end_o) begin
            log_fault($sformatf("patch word %0d: expected %h/%b/%b, got %h/%b/%b",
                                patch_index, exp.word, exp.item_end, exp.frame_end,
                                patch_word_o, last_of_item_o, frame_end_o));
          end
        end
        patch_index++;
      end
    end
  end

  // Write block_words, then read it back
  task automatic set_block_words(logic [LEN_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_BLOCK_WORDS;
    pwdata  <= APB_DW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    load_block_words(value);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== APB_DW'(value)) begin
      log_fault($sformatf("block_words readback: expected %h, got %h",
                          APB_DW'(value), prdata));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait until every item is taken, every patch word seen, and the block quiet
  task automatic wait_drained();
    int unsigned n;
    while (snapshot_words.size() != 0 || in_valid_i) begin
      @(posedge clk_i);
    end
    n = 0;
    while (expected_patch.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  // Push the first count words of a frame, derived from the last one sent or random
  task automatic queue_frame(int unsigned count, frame_mode_e mode);
    bit changing;
    logic [WORD_W-1:0] w;
    changing = 1'b0;
    for (int unsigned p = 0; p < count; p++) begin
      case (mode)
        FRM_KEEP: w = last_sent[p];
        FRM_FLIP: w = last_sent[p] ^ WORD_W'($urandom_range(1, 65535));
        FRM_SPARSE: begin
          w = last_sent[p];
          if ($urandom_range(0, 7) == 0) begin
            w = w ^ WORD_W'($urandom_range(1, 65535));
          end
        end
        FRM_BURST: begin
          if ($urandom_range(0, 5) == 0) begin
            changing = !changing;
          end
          w = changing ? last_sent[p] ^ WORD_W'($urandom_range(1, 65535)) : last_sent[p];
        end
        default: w = WORD_W'($urandom);
      endcase
      last_sent[p] = w;
      snapshot_words.push_back(w);
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned bw;
    int unsigned frames;
    int unsigned count;
    int unsigned pick;
    frame_mode_e mode;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Size 0 counts as one word: load, change, repeat, change back
    set_block_words('0);
    snapshot_words.push_back(16'h0000);
    snapshot_words.push_back(16'hffff);
    snapshot_words.push_back(16'hffff);
    snapshot_words.push_back(16'h0000);
    wait_drained();

    // Oversized value clamps to the largest frame; abort it part way
    set_block_words(LEN_W'(16'h7fff));
    snapshot_words.push_back(16'h1234);
    snapshot_words.push_back(16'ha5a5);
    snapshot_words.push_back(16'h5a5a);
    wait_drained();
    set_block_words(BW_RESET);
    snapshot_words.push_back(16'hffff);
    wait_drained();

    // One-word frames under a long receiver hold-off, so the block backs up
    set_block_words(LEN_W'(1));
    long_hold_ask++;
    snapshot_words.push_back(16'h0000);
    snapshot_words.push_back(16'hffff);
    snapshot_words.push_back(16'hffff);
    snapshot_words.push_back(WORD_W'($urandom));
    snapshot_words.push_back(WORD_W'($urandom));
    snapshot_words.push_back(16'h0000);
    snapshot_words.push_back(16'h8000);
    snapshot_words.push_back(16'h7fff);
    wait_drained();

    // Three-word frames: run closed by the frame end, run closed by an
    // unchanged word, and trailing unchanged words
    set_block_words(LEN_W'(3));
    snapshot_words.push_back(16'h0001);
    snapshot_words.push_back(16'h0002);
    snapshot_words.push_back(16'h0003);
    snapshot_words.push_back(16'h0001);
    snapshot_words.push_back(16'h0009);
    snapshot_words.push_back(16'h0009);
    snapshot_words.push_back(16'h0007);
    snapshot_words.push_back(16'h0009);
    snapshot_words.push_back(16'h0009);
    wait_drained();

    // Random phases; the first one is longer than a run can be
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase == 0) begin
        bw = $urandom_range(MAX_RUN + 1, MAX_RUN + 8);
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          bw = $urandom_range(1, 12);
        end else if (pick < 9) begin
          bw = $urandom_range(13, 80);
        end else begin
          bw = $urandom_range(81, 160);
        end
      end
      calm = ($urandom_range(0, 3) == 0);
      set_block_words(LEN_W'(bw));
      frames = (bw > 40) ? 2 : $urandom_range(2, 5);
      for (int unsigned f = 0; f < frames; f++) begin
        if (f == 0) begin
          mode = FRM_NOISE;
        end else if (phase == 0 && f == 1) begin
          mode = FRM_FLIP;
        end else begin
          mode = frame_mode_e'($urandom_range(0, 4));
        end
        count = bw;
        // Now and then cut the last frame short; the next write aborts it
        if (f == frames - 1 && bw > 1 && $urandom_range(0, 3) == 0) begin
          count = $urandom_range(1, bw - 1);
        end
        // Stop at the item budget
        if (count > RANDOM_ITEMS - sent) begin
          count = RANDOM_ITEMS - sent;
        end
        queue_frame(count, mode);
        sent += count;
      end
      wait_drained();
      phase++;
    end

    calm = 1'b0;
    wait_drained();
    if (expected_patch.size() != 0) begin
      log_fault($sformatf("%0d patch words never arrived", expected_patch.size()));
    end
    if (fault_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop for a hung run
  initial begin
    #(RUN_LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule : tb_state_delta_encoder

`default_nettype wire

// ===== filelist.f =====
rtl/sde_pkg.sv
rtl/sde_ram.sv
rtl/state_delta_encoder.sv
tb/tb_state_delta_encoder.sv
